// ----- rtl/core/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared types, codes and defaults for the task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int DEF_NUM_SLOTS = 64;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_BLOCK   = 3'd2,
        OP_UNBLOCK = 3'd3,
        OP_YIELD   = 3'd4,
        OP_EXIT    = 3'd5,
        OP_SCHED   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        SS_FREE     = 3'd0,
        SS_READY    = 3'd1,
        SS_RUNNING  = 3'd2,
        SS_SLEEPING = 3'd3,
        SS_BLOCKED  = 3'd4,
        SS_ZOMBIE   = 3'd5
    } t_slot_st;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_NOFREE = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_REFUSE = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] task_id;
    } t_sched_in;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] result_task;
        logic       switched;
        logic [5:0] previous_task;
    } t_sched_out;

endpackage

// ----- rtl/core/round_robin_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Slot table in a synchronous memory, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Op code 7, a refused exit, and an exit,
// schedule or yield with scheduling off go straight from decode to the result.
// Destroy, unblock and a block that makes no switch read the target slot
// first. Create scans the slot table for a free entry. Schedule, yield and
// exit scan the table for a ready entry, and so does a block of the current
// task. The pace of a scan is set by the single read port of the slot table,
// which returns one slot state per cycle during a scan. The result sits in an
// output register, so the next operation is taken while it waits. Slots that
// were never written read as free (slot 0 as running), so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_sched_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_sched_out o_out_data
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW = $clog2(NUM_SLOTS + 1);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] PICK_LEN  = CW'(NUM_SLOTS);
    localparam logic [CW-1:0] ALLOC_LEN = CW'(NUM_SLOTS - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DEC   = 10'b00_0000_0010,
        S_TGT   = 10'b00_0000_0100,
        S_ALLOC = 10'b00_0000_1000,
        S_PRV   = 10'b00_0001_0000,
        S_PRV_W = 10'b00_0010_0000,
        S_PICK  = 10'b00_0100_0000,
        S_SWAP  = 10'b00_1000_0000,
        S_SWAP2 = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    // slot table and its written-flags
    logic [2:0]           r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;

    t_state          r_state,     n_state;
    logic            r_out_valid, n_out_valid;
    t_sched_out      r_out_data,  n_out_data;
    logic [AW-1:0]   r_running,   n_running;
    logic [HW-1:0]   r_hint,      n_hint;
    logic            r_sched_en,  n_sched_en;
    logic            r_chk,       n_chk;
    logic            r_last,      n_last;
    logic [CW-1:0]   r_iss_cnt,   n_iss_cnt;
    logic [AW-1:0]   r_scan_addr, n_scan_addr;
    logic [2:0]      r_op,        n_op;
    logic [5:0]      r_tid,       n_tid;
    logic [AW-1:0]   r_prev_task, n_prev_task;
    t_status         r_status,    n_status;
    logic            r_created,   n_created;
    logic [AW-1:0]   r_newslot,   n_newslot;
    logic            r_switched,  n_switched;
    t_slot_st        r_prev_st,   n_prev_st;
    logic [AW-1:0]   r_next,      n_next;

    logic [2:0]      r_rd_data;
    logic            r_rd_vld;
    logic [AW-1:0]   r_rd_addr;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_slot_st        wr_data;
    t_slot_st        rd_state;
    logic [AW-1:0]   tgt_addr;
    logic            tgt_ok;
    logic            scan_pick;
    logic [CW-1:0]   scan_len;
    logic [AW-1:0]   scan_wrap;
    t_state          pick_entry;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // unwritten slots read as their reset state
    always_comb begin
        if (r_rd_vld) begin
            rd_state = t_slot_st'(r_rd_data);
        end else if (r_rd_addr == '0) begin
            rd_state = SS_RUNNING;
        end else begin
            rd_state = SS_FREE;
        end
    end

    assign tgt_addr   = AW'(r_tid);
    assign tgt_ok     = (32'(r_tid) < 32'(NUM_SLOTS)) && (rd_state != SS_FREE);
    assign scan_pick  = (r_state == S_PICK);
    assign scan_len   = scan_pick ? PICK_LEN : ALLOC_LEN;
    assign scan_wrap  = scan_pick ? AW'(0) : AW'(1);
    assign pick_entry = r_sched_en ? S_PRV : S_DONE;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_running   = r_running;
        n_hint      = r_hint;
        n_sched_en  = i_cfg_wr_en ? i_cfg_wr_data : r_sched_en;
        n_chk       = r_chk;
        n_last      = r_last;
        n_iss_cnt   = r_iss_cnt;
        n_scan_addr = r_scan_addr;
        n_op        = r_op;
        n_tid       = r_tid;
        n_prev_task = r_prev_task;
        n_status    = r_status;
        n_created   = r_created;
        n_newslot   = r_newslot;
        n_switched  = r_switched;
        n_prev_st   = r_prev_st;
        n_next      = r_next;
        rd_en       = 1'b0;
        rd_addr     = r_scan_addr;
        wr_en       = 1'b0;
        wr_addr     = r_running;
        wr_data     = SS_READY;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // issue one scan read per cycle until the whole range is covered
        if (r_state == S_ALLOC || r_state == S_PICK) begin
            if (r_iss_cnt != scan_len) begin
                rd_en       = 1'b1;
                rd_addr     = r_scan_addr;
                n_scan_addr = (r_scan_addr == LAST_SLOT) ? scan_wrap
                                                         : r_scan_addr + AW'(1);
                n_iss_cnt   = r_iss_cnt + CW'(1);
                n_chk       = 1'b1;
                n_last      = (r_iss_cnt == scan_len - CW'(1));
            end else begin
                n_chk = 1'b0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = i_in_data.op;
                    n_tid       = i_in_data.task_id;
                    n_prev_task = r_running;
                    n_status    = STS_OK;
                    n_created   = 1'b0;
                    n_switched  = 1'b0;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                case (t_op'(r_op))
                    OP_DESTROY, OP_BLOCK, OP_UNBLOCK: begin
                        rd_en   = 1'b1;
                        rd_addr = tgt_addr;
                        n_state = S_TGT;
                    end
                    OP_CREATE: begin
                        n_scan_addr = (r_hint >= HW'(NUM_SLOTS)) ? AW'(1) : AW'(r_hint);
                        n_iss_cnt   = '0;
                        n_chk       = 1'b0;
                        n_state     = S_ALLOC;
                    end
                    OP_EXIT: begin
                        if (r_running == '0) begin
                            n_status = STS_REFUSE;
                            n_state  = S_DONE;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_running;
                            wr_data = SS_ZOMBIE;
                            n_state = pick_entry;
                        end
                    end
                    OP_YIELD, OP_SCHED: begin
                        n_state = pick_entry;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_TGT: begin
                n_state = S_DONE;
                case (t_op'(r_op))
                    OP_DESTROY: begin
                        if (!tgt_ok) begin
                            n_status = STS_EMPTY;
                        end else if (tgt_addr == '0 || tgt_addr == r_running) begin
                            n_status = STS_REFUSE;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = tgt_addr;
                            wr_data = SS_FREE;
                        end
                    end
                    OP_BLOCK: begin
                        if (!tgt_ok) begin
                            n_status = STS_EMPTY;
                        end else if (tgt_addr == '0) begin
                            n_status = STS_REFUSE;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = tgt_addr;
                            wr_data = SS_BLOCKED;
                            if (tgt_addr == r_running) begin
                                n_state = pick_entry;
                            end
                        end
                    end
                    OP_UNBLOCK: begin
                        if (!tgt_ok) begin
                            n_status = STS_EMPTY;
                        end else if (rd_state == SS_BLOCKED || rd_state == SS_SLEEPING) begin
                            wr_en   = 1'b1;
                            wr_addr = tgt_addr;
                            wr_data = SS_READY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC: begin
                if (r_chk) begin
                    if (rd_state == SS_FREE) begin
                        wr_en     = 1'b1;
                        wr_addr   = r_rd_addr;
                        wr_data   = SS_READY;
                        n_created = 1'b1;
                        n_newslot = r_rd_addr;
                        n_hint    = HW'(r_rd_addr) + HW'(1);
                        n_state   = S_DONE;
                    end else if (r_last) begin
                        n_status = STS_NOFREE;
                        n_state  = S_DONE;
                    end
                end
            end
            S_PRV: begin
                rd_en   = 1'b1;
                rd_addr = r_running;
                n_state = S_PRV_W;
            end
            S_PRV_W: begin
                n_prev_st   = rd_state;
                n_scan_addr = (r_running == LAST_SLOT) ? AW'(0) : r_running + AW'(1);
                n_iss_cnt   = '0;
                n_chk       = 1'b0;
                n_state     = S_PICK;
            end
            S_PICK: begin
                if (r_chk) begin
                    if (rd_state == SS_READY) begin
                        n_next  = r_rd_addr;
                        n_state = S_SWAP;
                    end else if (r_last) begin
                        // nothing ready: fall back to the idle task
                        n_next  = '0;
                        n_state = S_SWAP;
                    end
                end
            end
            S_SWAP: begin
                if (r_next == r_running) begin
                    n_state = S_DONE;
                end else begin
                    if (r_prev_st == SS_RUNNING) begin
                        wr_en   = 1'b1;
                        wr_addr = r_running;
                        wr_data = SS_READY;
                    end
                    n_state = S_SWAP2;
                end
            end
            S_SWAP2: begin
                wr_en      = 1'b1;
                wr_addr    = r_next;
                wr_data    = SS_RUNNING;
                n_running  = r_next;
                n_switched = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_data.status          = r_status;
                    n_out_data.result_task     = 6'(r_created ? r_newslot : r_running);
                    n_out_data.switched        = r_switched;
                    n_out_data.previous_task   = 6'(r_prev_task);
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_running   <= '0;
            r_hint      <= HW'(1);
            r_sched_en  <= 1'b1;
            r_chk       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_running   <= n_running;
            r_hint      <= n_hint;
            r_sched_en  <= n_sched_en;
            r_chk       <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_last      <= n_last;
        r_iss_cnt   <= n_iss_cnt;
        r_scan_addr <= n_scan_addr;
        r_op        <= n_op;
        r_tid       <= n_tid;
        r_prev_task <= n_prev_task;
        r_status    <= n_status;
        r_created   <= n_created;
        r_newslot   <= n_newslot;
        r_switched  <= n_switched;
        r_prev_st   <= n_prev_st;
        r_next      <= n_next;
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // a read never races a write to the same slot
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("slot table read and write hit the same entry");

    a_swap_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP2) |-> (r_next != r_running))
        else $error("task switch to the task already running");

    a_running_only_on_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_running) |-> $past(r_state == S_SWAP2))
        else $error("current task changed outside a switch");

    a_hint_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint != '0)
        else $error("allocation hint points at the idle slot");

    a_accept_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> $past(r_state == S_IDLE && i_in_valid))
        else $error("decode entered without a transfer");

endmodule

// ----- verif/round_robin_task_scheduler_checker.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler checker
// Follows every transfer on both channels and every register write. For each
// operation taken, a private copy of the slot table predicts the result, and
// the results leaving the block are checked in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module round_robin_task_scheduler_checker
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_sched_in  i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_sched_out i_out_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int MAX_REPORTS = 10;

    t_slot_st   slot_tab [NUM_SLOTS];
    logic [5:0] cur_task;
    logic [6:0] next_hint;
    logic       sched_en;
    t_sched_out pending_results [$];

    // Round-robin pick after the current task, falling back to the idle task.
    function automatic logic switch_task();
        int  idx;
        int  nxt;
        logic found;
        nxt   = 0;
        found = 1'b0;
        if (!sched_en) return 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            idx = (int'(cur_task) + 1 + i) % NUM_SLOTS;
            if (!found && slot_tab[idx] == SS_READY) begin
                nxt   = idx;
                found = 1'b1;
            end
        end
        if (nxt == int'(cur_task)) return 1'b0;
        if (slot_tab[cur_task] == SS_RUNNING) slot_tab[cur_task] = SS_READY;
        slot_tab[nxt] = SS_RUNNING;
        cur_task      = nxt[5:0];
        return 1'b1;
    endfunction

    // Search from the hint to the top, then wrap from slot 1 up to the hint.
    function automatic int grab_slot();
        int   slot;
        logic found;
        slot  = NUM_SLOTS;
        found = 1'b0;
        for (int p = int'(next_hint); p < NUM_SLOTS; p++) begin
            if (!found && slot_tab[p] == SS_FREE) begin
                slot  = p;
                found = 1'b1;
            end
        end
        for (int p = 1; p < int'(next_hint) && p < NUM_SLOTS; p++) begin
            if (!found && slot_tab[p] == SS_FREE) begin
                slot  = p;
                found = 1'b1;
            end
        end
        if (found) next_hint = 7'(slot + 1);
        return slot;
    endfunction

    function automatic t_sched_out apply_operation(t_sched_in item);
        t_sched_out res;
        t_status    sts;
        logic [5:0] prev;
        logic [5:0] tid;
        logic       sw;
        logic       created;
        logic       occupied;
        int         new_slot;
        prev     = cur_task;
        tid      = item.task_id;
        sts      = STS_OK;
        sw       = 1'b0;
        created  = 1'b0;
        new_slot = 0;
        occupied = int'(tid) < NUM_SLOTS && slot_tab[tid] != SS_FREE;
        case (item.op)
            OP_CREATE: begin
                new_slot = grab_slot();
                if (new_slot >= NUM_SLOTS) begin
                    sts = STS_NOFREE;
                end else begin
                    slot_tab[new_slot] = SS_READY;
                    created            = 1'b1;
                end
            end
            OP_DESTROY: begin
                if (!occupied) sts = STS_EMPTY;
                else if (tid == 0 || tid == cur_task) sts = STS_REFUSE;
                else slot_tab[tid] = SS_FREE;
            end
            OP_BLOCK: begin
                if (!occupied) begin
                    sts = STS_EMPTY;
                end else if (tid == 0) begin
                    sts = STS_REFUSE;
                end else begin
                    slot_tab[tid] = SS_BLOCKED;
                    if (tid == cur_task) sw = switch_task();
                end
            end
            OP_UNBLOCK: begin
                if (!occupied) sts = STS_EMPTY;
                else if (slot_tab[tid] == SS_BLOCKED || slot_tab[tid] == SS_SLEEPING)
                    slot_tab[tid] = SS_READY;
            end
            OP_YIELD, OP_SCHED: begin
                sw = switch_task();
            end
            OP_EXIT: begin
                if (cur_task == 0) begin
                    sts = STS_REFUSE;
                end else begin
                    slot_tab[cur_task] = SS_ZOMBIE;
                    sw                 = switch_task();
                end
            end
            default: ;
        endcase
        res.status        = sts;
        res.result_task   = created ? new_slot[5:0] : cur_task;
        res.switched      = sw;
        res.previous_task = prev;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_sched_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) slot_tab[i] = SS_FREE;
            slot_tab[0] = SS_RUNNING;
            cur_task     = '0;
            next_hint    = 7'd1;
            sched_en     = 1'b1;
            o_fail_count = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) sched_en = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("sched check: unexpected result sts=%0d task=%0d sw=%0d prev=%0d",
                                 i_out_data.status, i_out_data.result_task,
                                 i_out_data.switched, i_out_data.previous_task);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.status != i_out_data.status
                        || want.result_task != i_out_data.result_task
                        || want.switched != i_out_data.switched
                        || want.previous_task != i_out_data.previous_task) begin
                        if (o_fail_count < MAX_REPORTS) begin
                            $write("sched check: expected sts=%0d task=%0d sw=%0d prev=%0d,",
                                   want.status, want.result_task, want.switched,
                                   want.previous_task);
                            $display(" got sts=%0d task=%0d sw=%0d prev=%0d",
                                     i_out_data.status, i_out_data.result_task,
                                     i_out_data.switched, i_out_data.previous_task);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(apply_operation(i_in_data));
        end
        o_pending <= pending_results.size();
    end

endmodule

// ----- verif/round_robin_task_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler testbench
// Drives scheduler operations through the input channel: a directed opening
// over refusals, empty slots and disabled scheduling, then random phases with
// varying idle and stall rates and scheduling switched on and off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module round_robin_task_scheduler_test;
    import rrts_pkg::*;

    localparam int         NUM_SLOTS     = DEF_NUM_SLOTS;
    localparam int         N_PHASES      = 8;
    localparam int         OPS_PER_PHASE = 240;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    t_sched_in  in_data     = '0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    t_sched_out out_data;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    round_robin_task_scheduler #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data)
    );

    round_robin_task_scheduler_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("round_robin_task_scheduler: mismatch");
            $finish;
        end
    end

    // Hold each operation until the block takes it; valid stays up between
    // back-to-back transfers.
    task automatic send_op(input logic [2:0] op, input logic [5:0] id);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_data.op      <= op;
        in_data.task_id <= id;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int         create_pct;
        int         id_span;
        int         pick;
        logic [2:0] op;
        logic [5:0] id;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_enable(1'b1);

        // Idle task alone: no switch, and every attack on it refused.
        send_op(OP_SCHED, 6'd0);
        send_op(OP_EXIT, 6'd0);
        send_op(OP_BLOCK, 6'd0);
        send_op(OP_DESTROY, 6'd0);
        send_op(OP_DESTROY, 6'd63);
        send_op(OP_UNBLOCK, 6'd5);
        send_op(OP_CREATE, 6'd63);
        send_op(OP_CREATE, 6'd0);
        send_op(OP_UNBLOCK, 6'd1);
        send_op(OP_YIELD, 6'd0);
        send_op(OP_DESTROY, 6'd1);
        send_op(OP_BLOCK, 6'd1);
        send_op(OP_UNBLOCK, 6'd1);
        send_op(OP_EXIT, 6'd42);
        send_op(OP_DESTROY, 6'd2);
        send_op(OP_UNUSED, 6'd63);
        send_op(OP_BLOCK, 6'd63);
        send_op(OP_CREATE, 6'd21);
        send_op(OP_SCHED, 6'd0);
        send_op(OP_BLOCK, 6'd3);
        // With scheduling off, a blocked or exited task keeps the processor.
        drain();
        write_enable(1'b0);
        send_op(OP_BLOCK, 6'd1);
        send_op(OP_YIELD, 6'd0);
        send_op(OP_EXIT, 6'd0);
        drain();
        write_enable(1'b1);
        send_op(OP_SCHED, 6'd0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            write_enable(ph % 3 != 1);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            // One phase floods creates to fill the table and hit the wrap.
            create_pct = (ph == 5) ? 85 : 20 + 5 * (ph % 4);
            id_span    = (ph == 5) ? 63 : 15;
            for (int n = 0; n < OPS_PER_PHASE; n++) begin
                if (ph == 1 && n == OPS_PER_PHASE / 2) drain();
                if ($urandom_range(0, 99) < create_pct) begin
                    op = OP_CREATE;
                end else begin
                    pick = $urandom_range(0, 12);
                    case (pick / 2)
                        0: op = OP_DESTROY;
                        1: op = OP_BLOCK;
                        2: op = OP_UNBLOCK;
                        3: op = OP_YIELD;
                        4: op = OP_SCHED;
                        5: op = OP_EXIT;
                        default: op = OP_UNUSED;
                    endcase
                end
                if ($urandom_range(0, 4) == 0) id = 6'($urandom_range(0, 63));
                else id = 6'($urandom_range(0, id_span));
                send_op(op, id);
            end
        end

        drain();
        stall_pct = 0;
        repeat (NUM_SLOTS + 16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("round_robin_task_scheduler: match");
        end else begin
            $display("round_robin_task_scheduler: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rrts_pkg.sv
rtl/core/round_robin_task_scheduler.sv
verif/round_robin_task_scheduler_checker.sv
verif/round_robin_task_scheduler_test.sv
